### rtl/core/atas_pkg.sv
// Shared types, constants and the arctangent table for the tilt-angle smoother.
`timescale 1ns / 1ps
package atas_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int STATE_W          = 24;
    localparam int STATE_SHIFT      = 7;
    localparam int ANGLE_W          = 15;
    localparam int TABLE_LEN        = 24;
    localparam int IDX_W            = 5;
    localparam int SQ_W             = 48;
    localparam int CX_W             = 28;
    localparam int CZ_W             = 25;
    localparam logic [15:0] WEIGHT_ONE   = 16'd32768;
    localparam logic [15:0] WEIGHT_RESET = 16'd6554;
    localparam int ANGLE_LIMIT      = 11520;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_WEIGHT   = 2'd0;
    localparam logic [1:0] REG_OFFSET_X = 2'd1;
    localparam logic [1:0] REG_OFFSET_Y = 2'd2;
    localparam logic [1:0] REG_OFFSET_Z = 2'd3;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_MUL,
        TS_UPD,
        TS_GO
    } t_top_state;

    typedef enum logic [2:0] {
        LS_IDLE,
        LS_SQR,
        LS_SUM,
        LS_ROOT,
        LS_ROT,
        LS_FIN
    } t_lane_state;

    typedef struct packed {
        logic                      done;
        logic signed [ANGLE_W-1:0] angle;
    } t_lane_stat;

    // atan(2^-i) in units of 2^-16 degree
    function automatic logic [21:0] atan_deg16(input logic [IDX_W-1:0] idx);
        logic [21:0] v;
        unique case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/accel_tilt_angle_smoother.sv
// Top level of the accelerometer tilt-angle smoother.
`timescale 1ns / 1ps
// Usage
//   Input channel: i_valid / o_ready carry one three-axis sample (i_accel_*).
//   Output channel: o_valid / i_ready carry three tilt angles (o_angle_*), Q8.7
//   degrees, one result per sample, in order.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 weight, 1..3 offsets X/Y/Z); write only while the block is idle.
// Timing
//   A sample is taken only when the block is idle. Smoothing (multiply, then
//   blend), a start state, then three lanes run in parallel: squares, sum,
//   24-step square root, CORDIC_STEPS rotations (capped at 24), rounding.
//   One sample is taken per result, once the previous result has left the lanes.
//   The square root and CORDIC iterations take most of the time to a result.
// Reset and stall
//   Reset clears the smoothing state, sets the weight to 6554 and the offsets
//   to zero. A held result sits in the output register; the next sample is
//   still taken and processed, and its angles wait until the register frees.
module accel_tilt_angle_smoother
    import atas_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [15:0]                    i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel_z,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [ANGLE_W-1:0]      o_angle_x,
    output logic signed [ANGLE_W-1:0]      o_angle_y,
    output logic signed [ANGLE_W-1:0]      o_angle_z
);

    t_top_state r_state, n_state;

    logic        [15:0]             r_weight;
    logic signed [SAMPLE_WIDTH-1:0] r_off   [3];
    logic signed [SAMPLE_WIDTH-1:0] r_smp   [3];
    logic signed [STATE_W-1:0]      smooth  [3];
    t_lane_stat                     stat    [3];
    logic signed [ANGLE_W-1:0]      r_ang   [3];
    logic                           r_ovalid;

    logic all_done, any_done, load_out, lane_busy;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WEIGHT_RESET;
            r_off[0] <= '0;
            r_off[1] <= '0;
            r_off[2] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WEIGHT:   r_weight <= (i_cfg_data > WEIGHT_ONE) ? WEIGHT_ONE : i_cfg_data;
                REG_OFFSET_X: r_off[0] <= SAMPLE_WIDTH'(i_cfg_data);
                REG_OFFSET_Y: r_off[1] <= SAMPLE_WIDTH'(i_cfg_data);
                REG_OFFSET_Z: r_off[2] <= SAMPLE_WIDTH'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Sample capture
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_smp[0] <= i_accel_x;
            r_smp[1] <= i_accel_y;
            r_smp[2] <= i_accel_z;
        end
    end

    // Smoothing lanes
    for (genvar k = 0; k < 3; k++) begin : g_smooth
        atas_smooth #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_smooth (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_mul    (r_state == TS_MUL),
            .i_upd    (r_state == TS_UPD),
            .i_sample (r_smp[k]),
            .i_offset (r_off[k]),
            .i_weight (r_weight),
            .o_state  (smooth[k])
        );
    end

    // Tilt lanes: each axis over the other two
    atas_tilt #(.CORDIC_STEPS(CORDIC_STEPS)) u_tilt_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_state == TS_GO),
        .i_a(smooth[0]), .i_b(smooth[1]), .i_c(smooth[2]), .o_stat(stat[0])
    );
    atas_tilt #(.CORDIC_STEPS(CORDIC_STEPS)) u_tilt_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_state == TS_GO),
        .i_a(smooth[1]), .i_b(smooth[0]), .i_c(smooth[2]), .o_stat(stat[1])
    );
    atas_tilt #(.CORDIC_STEPS(CORDIC_STEPS)) u_tilt_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_state == TS_GO),
        .i_a(smooth[2]), .i_b(smooth[0]), .i_c(smooth[1]), .o_stat(stat[2])
    );

    assign all_done = stat[0].done && stat[1].done && stat[2].done;
    assign any_done = stat[0].done || stat[1].done || stat[2].done;

    // Lanes hold a result until it reaches the output register
    logic r_pending;
    assign lane_busy = r_pending;
    assign load_out  = r_pending && all_done && (!r_ovalid || i_ready);

    // Control sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            TS_IDLE: if (i_valid) n_state = TS_MUL;
            TS_MUL:  n_state = TS_UPD;
            TS_UPD:  n_state = TS_GO;
            TS_GO:   n_state = TS_IDLE;
            default: n_state = TS_IDLE;
        endcase
    end

    assign o_ready = (r_state == TS_IDLE) && !lane_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= TS_IDLE;
            r_pending <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (r_state != TS_IDLE || o_ready) begin
                r_state <= (r_state == TS_IDLE && !i_valid) ? TS_IDLE : n_state;
            end
            if (r_state == TS_GO) begin
                r_pending <= 1'b1;
            end else if (load_out) begin
                r_pending <= 1'b0;
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Merge: output register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_ang[0] <= stat[0].angle;
            r_ang[1] <= stat[1].angle;
            r_ang[2] <= stat[2].angle;
        end
    end

    assign o_valid   = r_ovalid;
    assign o_angle_x = r_ang[0];
    assign o_angle_y = r_ang[1];
    assign o_angle_z = r_ang[2];

    // Checks
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_ovalid || i_ready))
        else $error("result register overwritten while stalled");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == TS_GO) |=> !any_done)
        else $error("lane reported done right after start");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |-> !r_pending)
        else $error("sample taken while lanes still hold a result");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_angle_x <= ANGLE_W'(ANGLE_LIMIT) && o_angle_x >= -ANGLE_W'(ANGLE_LIMIT)))
        else $error("angle beyond ninety degrees");

endmodule

### rtl/core/atas_smooth.sv
// One axis of offset removal and exponential smoothing.
`timescale 1ns / 1ps
module atas_smooth
    import atas_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_mul,
    input  logic                           i_upd,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] i_offset,
    input  logic        [15:0]             i_weight,
    output logic signed [STATE_W-1:0]      o_state
);

    localparam int RW = SAMPLE_WIDTH + 1;
    localparam int TW = (SAMPLE_WIDTH + STATE_SHIFT + 1 > STATE_W + 1) ?
                        SAMPLE_WIDTH + STATE_SHIFT + 1 : STATE_W + 1;
    localparam int PW = 17 + STATE_W + 1;

    logic signed [STATE_W-1:0] r_state;
    logic signed [PW-1:0]      r_prod;

    logic signed [RW-1:0]      raw;
    logic signed [TW-1:0]      scaled;
    logic signed [STATE_W-1:0] target;
    logic signed [STATE_W:0]   diff;
    logic signed [PW:0]        rnd;
    logic signed [PW-15:0]     step;
    logic signed [PW-14:0]     sum;
    logic signed [STATE_W-1:0] n_state;

    // Offset removal, scaling and saturation to the state range
    always_comb begin
        raw    = RW'(i_sample) - RW'(i_offset);
        scaled = TW'(raw) <<< STATE_SHIFT;
        if (scaled > TW'(signed'(25'sd8388607))) begin
            target = 24'sh7FFFFF;
        end else if (scaled < TW'(signed'(-25'sd8388608))) begin
            target = 24'sh800000;
        end else begin
            target = scaled[STATE_W-1:0];
        end
        diff = (STATE_W+1)'(target) - (STATE_W+1)'(r_state);
    end

    // Rounded blend and clamp
    always_comb begin
        rnd  = (PW+1)'(r_prod) + (PW+1)'(16384);
        step = (PW-14)'(rnd >>> 15);
        sum  = (PW-13)'(r_state) + (PW-13)'(step);
        if (sum > (PW-13)'(signed'(25'sd8388607))) begin
            n_state = 24'sh7FFFFF;
        end else if (sum < (PW-13)'(signed'(-25'sd8388608))) begin
            n_state = 24'sh800000;
        end else begin
            n_state = sum[STATE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mul) begin
            r_prod <= signed'({1'b0, i_weight}) * diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_upd) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

### rtl/core/atas_tilt.sv
// One tilt lane: sum of squares, iterative square root, CORDIC arctangent.
`timescale 1ns / 1ps
module atas_tilt
    import atas_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [STATE_W-1:0] i_a,
    input  logic signed [STATE_W-1:0] i_b,
    input  logic signed [STATE_W-1:0] i_c,
    output t_lane_stat                o_stat
);

    localparam int EFF_STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

    t_lane_state r_state, n_state;

    logic signed [STATE_W-1:0] r_a, r_b, r_c;
    logic        [SQ_W-1:0]    r_bb, r_cc;
    logic        [SQ_W-1:0]    r_v, r_res, r_bit;
    logic signed [CX_W-1:0]    r_x, r_y;
    logic signed [CZ_W-1:0]    r_z;
    logic        [IDX_W-1:0]   r_i;
    logic                      r_done;
    logic signed [ANGLE_W-1:0] r_angle;

    logic        [SQ_W-1:0]    trial;
    logic signed [CX_W-1:0]    xs, ys;
    logic signed [CZ_W-1:0]    tz;
    logic signed [CZ_W:0]      zr;
    logic signed [CZ_W-9:0]    zq;
    logic signed [ANGLE_W-1:0] fin_angle;

    always_comb begin
        trial = r_res + r_bit;
        xs    = r_x >>> r_i;
        ys    = r_y >>> r_i;
        tz    = CZ_W'(atan_deg16(r_i));
        zr    = (CZ_W+1)'(r_z) + (CZ_W+1)'(256);
        zq    = (CZ_W-8)'(zr >>> 9);
        if (zq > (CZ_W-8)'(ANGLE_LIMIT)) begin
            fin_angle = ANGLE_W'(ANGLE_LIMIT);
        end else if (zq < -(CZ_W-8)'(ANGLE_LIMIT)) begin
            fin_angle = -ANGLE_W'(ANGLE_LIMIT);
        end else begin
            fin_angle = zq[ANGLE_W-1:0];
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            LS_IDLE: if (i_start) n_state = LS_SQR;
            LS_SQR:  n_state = LS_SUM;
            LS_SUM:  n_state = LS_ROOT;
            LS_ROOT: begin
                if (r_bit == '0) begin
                    if (r_a == '0 || r_res == '0) begin
                        n_state = LS_IDLE;
                    end else begin
                        n_state = LS_ROT;
                    end
                end
            end
            LS_ROT:  if (r_i == IDX_W'(EFF_STEPS - 1)) n_state = LS_FIN;
            LS_FIN:  n_state = LS_IDLE;
            default: n_state = LS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_start) begin
                r_done <= 1'b0;
            end else if ((r_state == LS_ROOT || r_state == LS_FIN) && n_state == LS_IDLE) begin
                r_done <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            LS_IDLE: begin
                r_a <= i_a;
                r_b <= i_b;
                r_c <= i_c;
            end
            LS_SQR: begin
                r_bb <= SQ_W'(r_b * r_b);
                r_cc <= SQ_W'(r_c * r_c);
            end
            LS_SUM: begin
                r_v   <= r_bb + r_cc;
                r_res <= '0;
                r_bit <= SQ_W'(1) << (SQ_W - 2);
            end
            LS_ROOT: begin
                if (r_bit != '0) begin
                    if (r_v >= trial) begin
                        r_v   <= r_v - trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end else begin
                    // root finished: handle the degenerate cases here
                    r_x <= CX_W'(r_res);
                    r_y <= CX_W'(r_a);
                    r_z <= '0;
                    r_i <= '0;
                    if (r_a == '0) begin
                        r_angle <= '0;
                    end else if (r_res == '0) begin
                        r_angle <= r_a[STATE_W-1] ? -ANGLE_W'(ANGLE_LIMIT)
                                                  : ANGLE_W'(ANGLE_LIMIT);
                    end
                end
            end
            LS_ROT: begin
                if (!r_y[CX_W-1]) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + tz;
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - tz;
                end
                r_i <= r_i + 1'b1;
            end
            LS_FIN:  r_angle <= fin_angle;
            default: ;
        endcase
    end

    assign o_stat.done  = r_done;
    assign o_stat.angle = r_angle;

endmodule
